/* rtl/moving_average_window_assert.svh */
// assertion macros shared by the moving average checker
`ifndef MOVING_AVERAGE_WINDOW_ASSERT_SVH
`define MOVING_AVERAGE_WINDOW_ASSERT_SVH

// same-cycle implication, sampled on clk, off during reset
`define MAVG_ASSERT_NOW(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication, sampled on clk, off during reset
`define MAVG_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

/* rtl/mavg_pkg.sv */
// shared constants and controller/datapath command and status types
`default_nettype none

package mavg_pkg;

	localparam int MAX_WINDOW_DEF  = 64;
	localparam int SAMPLE_BITS_DEF = 16;
	localparam int CFG_W           = 7;
	localparam int WIN_RESET       = 8;

	// commands from controller to datapath
	typedef struct packed {
		logic accept;
		logic update;
		logic prep;
		logic div_step;
		logic fix;
		logic load_out;
	} mavg_cmd_t;

	// status from datapath to controller
	typedef struct packed {
		logic window_full;
	} mavg_sts_t;

endpackage

`default_nettype wire

/* rtl/mavg_if.sv */
// valid/ready stream interfaces for samples and results
`default_nettype none

interface mavg_sample_if #(
	parameter int SAMPLE_BITS = mavg_pkg::SAMPLE_BITS_DEF
) ();
	logic                          valid;
	logic                          ready;
	logic signed [SAMPLE_BITS-1:0] sample;

	modport source (output valid, output sample, input ready);
	modport sink (input valid, input sample, output ready);
endinterface

interface mavg_result_if #(
	parameter int SAMPLE_BITS = mavg_pkg::SAMPLE_BITS_DEF
) ();
	logic                          valid;
	logic                          ready;
	logic signed [SAMPLE_BITS-1:0] average;
	logic                          window_full;

	modport source (output valid, output average, output window_full, input ready);
	modport sink (input valid, input average, input window_full, output ready);
endinterface

`default_nettype wire

/* rtl/mavg_ram.sv */
// generic simple dual-port ram with registered read
`default_nettype none

module mavg_ram #(
	parameter int WIDTH = 16,
	parameter int DEPTH = 64
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic                     re,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output      logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	// write port
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
	end

	// registered read port
	always_ff @(posedge clk) begin
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

`default_nettype wire

/* rtl/mavg_datapath.sv */
// ring store, running sum, restoring divider and output register
`default_nettype none

module mavg_datapath #(
	parameter int MAX_WINDOW  = mavg_pkg::MAX_WINDOW_DEF,
	parameter int SAMPLE_BITS = mavg_pkg::SAMPLE_BITS_DEF
) (
	input  wire logic                           clk,
	input  wire logic                           arst_n,
	input  wire logic                           cfg_we,
	input  wire logic [mavg_pkg::CFG_W-1:0]     cfg_len,
	input  wire logic signed [SAMPLE_BITS-1:0]  sample,
	input  wire mavg_pkg::mavg_cmd_t            cmd,
	output      mavg_pkg::mavg_sts_t            sts,
	output      logic signed [SAMPLE_BITS-1:0]  average,
	output      logic                           window_full
);

	localparam int SLOT_W = $clog2(MAX_WINDOW);
	localparam int LEN_W  = $clog2(MAX_WINDOW + 1);
	localparam int SUM_W  = SAMPLE_BITS + SLOT_W;
	localparam int CMP_W  = (LEN_W > mavg_pkg::CFG_W) ? LEN_W : mavg_pkg::CFG_W;
	localparam int LEN_RESET = (mavg_pkg::WIN_RESET > MAX_WINDOW) ? MAX_WINDOW
		: mavg_pkg::WIN_RESET;

	logic [LEN_W-1:0]              len_q;
	logic [LEN_W-1:0]              len_clamped;
	logic [SLOT_W-1:0]             slot_q;
	logic [LEN_W-1:0]              slot_inc;
	logic [LEN_W-1:0]              fill_q;
	logic signed [SUM_W-1:0]       sum_q;
	logic signed [SUM_W-1:0]       sum_next;
	logic signed [SAMPLE_BITS-1:0] sample_q;
	logic [SAMPLE_BITS-1:0]        old_word;
	logic [SUM_W-1:0]              sum_mag;
	logic [SUM_W-1:0]              quo_q;
	logic [LEN_W-1:0]              rem_q;
	logic                          neg_q;
	logic [LEN_W:0]                rem_shift;
	logic                          quo_bit;
	logic [SUM_W-1:0]              quo_signed;
	logic signed [SAMPLE_BITS-1:0] res_q;
	logic                          res_full_q;

	// clamp written length to 1..MAX_WINDOW
	always_comb begin
		if (cfg_len == '0) begin
			len_clamped = LEN_W'(1);
		end else if (CMP_W'(cfg_len) > CMP_W'(MAX_WINDOW)) begin
			len_clamped = LEN_W'(MAX_WINDOW);
		end else begin
			len_clamped = LEN_W'(cfg_len);
		end
	end

	// sample ring store
	mavg_ram #(
		.WIDTH(SAMPLE_BITS),
		.DEPTH(MAX_WINDOW)
	) u_store (
		.clk  (clk),
		.we   (cmd.update),
		.waddr(slot_q),
		.wdata(sample_q),
		.re   (cmd.accept),
		.raddr(slot_q),
		.rdata(old_word)
	);

	// running sum update and ring pointer advance
	assign sts.window_full = (fill_q >= len_q);
	assign slot_inc        = LEN_W'(slot_q) + LEN_W'(1);

	always_comb begin
		sum_next = sum_q + SUM_W'(sample_q);
		if (sts.window_full) begin
			sum_next = sum_next - SUM_W'($signed(old_word));
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			len_q  <= LEN_W'(LEN_RESET);
			slot_q <= '0;
			fill_q <= '0;
			sum_q  <= '0;
		end else if (cfg_we) begin
			len_q  <= len_clamped;
			slot_q <= '0;
			fill_q <= '0;
			sum_q  <= '0;
		end else if (cmd.update) begin
			sum_q <= sum_next;
			if (!sts.window_full) begin
				fill_q <= fill_q + LEN_W'(1);
			end
			if (slot_inc >= len_q) begin
				slot_q <= '0;
			end else begin
				slot_q <= slot_inc[SLOT_W-1:0];
			end
		end
	end

	// sample capture
	always_ff @(posedge clk) begin
		if (cmd.accept) begin
			sample_q <= sample;
		end
	end

	// restoring divider, one quotient bit per step
	assign sum_mag    = sum_q[SUM_W-1] ? SUM_W'(-sum_q) : SUM_W'(sum_q);
	assign rem_shift  = {rem_q, quo_q[SUM_W-1]};
	assign quo_bit    = (rem_shift >= {1'b0, len_q});
	assign quo_signed = neg_q ? (~quo_q + SUM_W'(1)) : quo_q;

	always_ff @(posedge clk) begin
		if (cmd.prep) begin
			quo_q      <= sum_mag;
			rem_q      <= '0;
			neg_q      <= sum_q[SUM_W-1];
			res_q      <= '0;
			res_full_q <= sts.window_full;
		end else if (cmd.div_step) begin
			quo_q <= {quo_q[SUM_W-2:0], quo_bit};
			if (quo_bit) begin
				rem_q <= LEN_W'(rem_shift - {1'b0, len_q});
			end else begin
				rem_q <= rem_shift[LEN_W-1:0];
			end
		end else if (cmd.fix) begin
			res_q <= $signed(quo_signed[SAMPLE_BITS-1:0]);
		end
	end

	// output word register
	always_ff @(posedge clk) begin
		if (cmd.load_out) begin
			average     <= res_q;
			window_full <= res_full_q;
		end
	end

endmodule

`default_nettype wire

/* rtl/mavg_ctrl.sv */
// sequencing state machine and output valid tracking
`default_nettype none

module mavg_ctrl #(
	parameter int SUM_W = mavg_pkg::SAMPLE_BITS_DEF + $clog2(mavg_pkg::MAX_WINDOW_DEF)
) (
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire logic                 in_valid,
	output      logic                 in_ready,
	output      logic                 out_valid,
	input  wire logic                 out_ready,
	input  wire mavg_pkg::mavg_sts_t  sts,
	output      mavg_pkg::mavg_cmd_t  cmd
);

	localparam int CNT_W = $clog2(SUM_W);

	typedef enum logic [2:0] {
		S_IDLE,
		S_UPDATE,
		S_PREP,
		S_DIV,
		S_FIX,
		S_OUT
	} state_t;

	state_t           state_q;
	logic [CNT_W-1:0] cnt_q;
	logic             out_valid_q;
	logic             out_free;

	assign in_ready  = (state_q == S_IDLE);
	assign out_valid = out_valid_q;
	assign out_free  = !out_valid_q || out_ready;

	// command decode
	always_comb begin
		cmd          = '0;
		cmd.accept   = (state_q == S_IDLE) && in_valid;
		cmd.update   = (state_q == S_UPDATE);
		cmd.prep     = (state_q == S_PREP);
		cmd.div_step = (state_q == S_DIV);
		cmd.fix      = (state_q == S_FIX);
		cmd.load_out = (state_q == S_OUT) && out_free;
	end

	// state, step counter and output valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			cnt_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (cmd.load_out) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				S_IDLE: begin
					if (in_valid) begin
						state_q <= S_UPDATE;
					end
				end
				S_UPDATE: begin
					state_q <= S_PREP;
				end
				S_PREP: begin
					cnt_q <= '0;
					if (sts.window_full) begin
						state_q <= S_DIV;
					end else begin
						state_q <= S_OUT;
					end
				end
				S_DIV: begin
					cnt_q <= cnt_q + CNT_W'(1);
					if (cnt_q == CNT_W'(SUM_W - 1)) begin
						state_q <= S_FIX;
					end
				end
				S_FIX: begin
					state_q <= S_OUT;
				end
				S_OUT: begin
					if (out_free) begin
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

endmodule

`default_nettype wire

/* rtl/moving_average_window.sv */
// Moving average over the last window_length samples, one result word per sample.
// A word that fills the window passes update, prep, the bit-serial restoring divider and fix
// before the output register; while filling, the divider and fix are skipped.
// A new sample is taken only after the last result word is loaded into the output register.
// Reset (arst_n low): window length 8, store empty, sum and fill count zero, no word valid.
// A write of window_length also empties the window; the store itself is never cleared.
`default_nettype none

module moving_average_window #(
	parameter int MAX_WINDOW  = mavg_pkg::MAX_WINDOW_DEF,
	parameter int SAMPLE_BITS = mavg_pkg::SAMPLE_BITS_DEF
) (
	input  wire logic                       clk,
	input  wire logic                       arst_n,
	input  wire logic                       window_length_we,
	input  wire logic [mavg_pkg::CFG_W-1:0] window_length,
	mavg_sample_if.sink                     samples,
	mavg_result_if.source                   results
);

	localparam int SUM_W = SAMPLE_BITS + $clog2(MAX_WINDOW);

	mavg_pkg::mavg_cmd_t cmd;
	mavg_pkg::mavg_sts_t sts;

	// sequencer
	mavg_ctrl #(
		.SUM_W(SUM_W)
	) u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (samples.valid),
		.in_ready (samples.ready),
		.out_valid(results.valid),
		.out_ready(results.ready),
		.sts      (sts),
		.cmd      (cmd)
	);

	// store, sum and divider
	mavg_datapath #(
		.MAX_WINDOW (MAX_WINDOW),
		.SAMPLE_BITS(SAMPLE_BITS)
	) u_dp (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg_we     (window_length_we),
		.cfg_len    (window_length),
		.sample     (samples.sample),
		.cmd        (cmd),
		.sts        (sts),
		.average    (results.average),
		.window_full(results.window_full)
	);

endmodule

`default_nettype wire

/* rtl/mavg_checker.sv */
// port-level checker for the moving average block and its bind
`default_nettype none

`include "moving_average_window_assert.svh"

module mavg_checker #(
	parameter int SAMPLE_BITS = mavg_pkg::SAMPLE_BITS_DEF
) (
	input wire logic                   clk,
	input wire logic                   arst_n,
	input wire logic                   samples_valid,
	input wire logic                   samples_ready,
	input wire logic                   results_valid,
	input wire logic                   results_ready,
	input wire logic [SAMPLE_BITS-1:0] results_average,
	input wire logic                   results_window_full
);

	// one word in flight: ready drops right after a word is taken
	`MAVG_ASSERT_NEXT(a_busy_after_accept, samples_valid && samples_ready, !samples_ready, "ready held after accept")

	// no result can rise in the cycle after a word is taken
	`MAVG_ASSERT_NEXT(a_no_instant_result, samples_valid && samples_ready, !$rose(results_valid), "result too early")

	// average reads zero while the window is still filling
	`MAVG_ASSERT_NOW(a_zero_while_filling, results_valid && !results_window_full, results_average == '0, "nonzero average while filling")

	// stalled result stays offered
	`MAVG_ASSERT_NEXT(a_valid_holds, results_valid && !results_ready, results_valid, "result dropped while stalled")

	// stalled result keeps its payload
	`MAVG_ASSERT_NEXT(a_payload_holds, results_valid && !results_ready, $stable(results_average) && $stable(results_window_full), "result changed while stalled")

endmodule

bind moving_average_window mavg_checker #(
	.SAMPLE_BITS(SAMPLE_BITS)
) u_mavg_checker (
	.clk                (clk),
	.arst_n             (arst_n),
	.samples_valid      (samples.valid),
	.samples_ready      (samples.ready),
	.results_valid      (results.valid),
	.results_ready      (results.ready),
	.results_average    (results.average),
	.results_window_full(results.window_full)
);

`default_nettype wire
